/* src/qte_pkg.sv */
`timescale 1ns / 1ps

package qte_pkg;

  localparam int COMP_W       = 24;
  localparam int PROD_W       = 2 * COMP_W;
  localparam int ARG_W        = 52;
  localparam int CX_W         = 44;
  localparam int ACC_W        = 30;
  localparam int ACC_FRAC     = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int SQ_W         = 63;
  localparam int RT_W         = 32;
  localparam int PS_W         = 33;
  localparam int NORM_MSB     = 40;
  localparam int SHIFT_W      = 7;
  localparam int LANES        = 3;

  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_ROLL  = 2;

  localparam logic signed [ACC_W-1:0] PI_ACC      = 30'sd52707179;
  localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 30'sd26353589;

  localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'sd13176795, 30'sd7778716, 30'sd4110060, 30'sd2086331, 30'sd1047214,
    30'sd524117, 30'sd262123, 30'sd131069, 30'sd65536, 30'sd32768,
    30'sd16384, 30'sd8192, 30'sd4096, 30'sd2048, 30'sd1024, 30'sd512,
    30'sd256, 30'sd128, 30'sd64, 30'sd32, 30'sd16, 30'sd8, 30'sd4, 30'sd2
  };

  typedef struct packed {
    logic                    nul;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ACC_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                    zero;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] roll_x;
  } args_t;

  typedef struct packed {
    args_t                  a;
    logic signed [PS_W-1:0] p;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sqrt_t;

endpackage

/* src/qte_if.sv */
`timescale 1ns / 1ps

interface qte_quat_if #(parameter int COMPONENT_BITS = 16) ();
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;
  logic signed [COMPONENT_BITS-1:0] quat_w;
  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

interface qte_euler_if #(parameter int ANGLE_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-2:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic                         zero_norm;
  modport source (output valid, output yaw_angle, output pitch_angle,
                  output roll_angle, output zero_norm, input ready);
  modport sink (input valid, input yaw_angle, input pitch_angle,
                input roll_angle, input zero_norm, output ready);
endinterface

/* src/qte_sqrt_cell.sv */
`timescale 1ns / 1ps

module qte_sqrt_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d_i,
  input  side_t side_i,
  output sqrt_t d_o,
  output side_t side_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * STEP);

  logic [SQ_W-1:0] trial;
  sqrt_t           d_nxt;
  sqrt_t           d_r;
  side_t           side_r;

  always_comb begin
    trial = d_i.res + BIT;
    if (d_i.v >= trial) begin
      d_nxt.v   = d_i.v - trial;
      d_nxt.res = (d_i.res >> 1) + BIT;
    end else begin
      d_nxt.v   = d_i.v;
      d_nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_i;
    end
  end

  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

/* src/qte_cordic_cell.sv */
`timescale 1ns / 1ps

module qte_cordic_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  cordic_t [LANES-1:0]   lane_i,
  input  logic                  zero_i,
  output cordic_t [LANES-1:0]   lane_o,
  output logic                  zero_o
);

  cordic_t [LANES-1:0] lane_nxt;
  cordic_t [LANES-1:0] lane_r;
  logic                zero_r;

  always_comb begin
    logic signed [CX_W-1:0]  xv;
    logic signed [CX_W-1:0]  yv;
    logic signed [ACC_W-1:0] zv;
    for (int l = 0; l < LANES; l++) begin
      xv = lane_i[l].x;
      yv = lane_i[l].y;
      zv = lane_i[l].z;
      lane_nxt[l].nul = lane_i[l].nul;
      if (yv < 0) begin
        lane_nxt[l].x = xv - (yv >>> STEP);
        lane_nxt[l].y = yv + (xv >>> STEP);
        lane_nxt[l].z = zv - ATAN_TAB[STEP];
      end else begin
        lane_nxt[l].x = xv + (yv >>> STEP);
        lane_nxt[l].y = yv - (xv >>> STEP);
        lane_nxt[l].z = zv + ATAN_TAB[STEP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      zero_r <= zero_i;
    end
  end

  assign lane_o = lane_r;
  assign zero_o = zero_r;

endmodule

/* src/qte_norm.sv */
`timescale 1ns / 1ps

module qte_norm import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    en_a,
  input  logic                    en_b,
  input  logic signed [ARG_W-1:0] y_i,
  input  logic signed [ARG_W-1:0] x_i,
  output cordic_t                 c_o
);

  logic [ARG_W-1:0]          ax;
  logic [ARG_W-1:0]          ay;
  logic [ARG_W-1:0]          m;
  logic [5:0]                msb;
  logic signed [SHIFT_W-1:0] sh_nxt;
  logic signed [ARG_W-1:0]   x_r;
  logic signed [ARG_W-1:0]   y_r;
  logic signed [SHIFT_W-1:0] sh_r;
  logic                      nul_r;
  logic signed [SHIFT_W-1:0] nsh;
  logic signed [ARG_W-1:0]   xs;
  logic signed [ARG_W-1:0]   ys;
  cordic_t                   c_nxt;
  cordic_t                   c_r;

  always_comb begin
    ax  = x_i[ARG_W-1] ? ARG_W'(-x_i) : ARG_W'(x_i);
    ay  = y_i[ARG_W-1] ? ARG_W'(-y_i) : ARG_W'(y_i);
    m   = (ax > ay) ? ax : ay;
    msb = '0;
    for (int i = 0; i < ARG_W; i++) begin
      if (m[i]) begin
        msb = 6'(i);
      end
    end
    sh_nxt = SHIFT_W'($signed({1'b0, msb}) - NORM_MSB);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      x_r   <= x_i;
      y_r   <= y_i;
      sh_r  <= sh_nxt;
      nul_r <= (m == '0);
    end
  end

  always_comb begin
    nsh = -sh_r;
    if (!sh_r[SHIFT_W-1]) begin
      xs = x_r >>> sh_r[5:0];
      ys = y_r >>> sh_r[5:0];
    end else begin
      xs = x_r <<< nsh[5:0];
      ys = y_r <<< nsh[5:0];
    end
    c_nxt.nul = nul_r;
    c_nxt.x   = CX_W'(xs);
    c_nxt.y   = CX_W'(ys);
    c_nxt.z   = '0;
    if (xs < 0) begin
      c_nxt.z = (ys >= 0) ? PI_ACC : -PI_ACC;
      c_nxt.x = CX_W'(-xs);
      c_nxt.y = CX_W'(-ys);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule

/* src/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
// Quaternion to Euler angles.
// The in_quat channel takes one quaternion (x, y, z, w) per request; the
// out_euler channel returns yaw, pitch and roll in radians together with a
// flag for a zero-length quaternion. Both channels use valid and ready.
// One request is accepted per cycle while in_quat ready is high. The chain
// holds the product, sum and pitch operand scaling stages, 32 square root
// cells that each settle one result bit, the operand normalization stages,
// 24 CORDIC cells that each apply one micro-rotation to all three angles,
// and the output register. Every stage holds its own valid bit, so a stall
// at the output only stops the stages that are full and empty stages keep
// taking requests; in_quat ready drops only when the whole chain is full and
// out_euler is stalled. Reset clears all valid bits and there is no clearing
// pass.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_BITS     = 16
) (
  input logic          clk,
  input logic          rst_n,
  qte_quat_if.sink     in_quat,
  qte_euler_if.source  out_euler
);

  localparam int ST_PROD = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_PMSB = 2;
  localparam int ST_PSH  = 3;
  localparam int ST_PMUL = 4;
  localparam int ST_PSUB = 5;
  localparam int ST_SQRT = 6;
  localparam int ST_NA   = ST_SQRT + SQRT_STEPS;
  localparam int ST_NB   = ST_NA + 1;
  localparam int ST_CORD = ST_NB + 1;
  localparam int ST_OUT  = ST_CORD + CORDIC_STEPS;
  localparam int NS      = ST_OUT + 1;

  localparam int LSH  = (COMPONENT_BITS > COMP_W) ? COMPONENT_BITS - COMP_W : 0;
  localparam int NS_W = 31;
  localparam int KW   = 5;

  localparam int FRAC = ANGLE_BITS - 3;
  localparam int SH_R = (FRAC < ACC_FRAC) ? ACC_FRAC - FRAC : 0;
  localparam int SH_L = (FRAC > ACC_FRAC) ? FRAC - ACC_FRAC : 0;
  localparam int OW   = 40;
  localparam logic signed [OW-1:0] RND = $signed((OW'(1) << SH_R) >> 1);

  function automatic logic signed [OW-1:0] to_out(input logic signed [OW-1:0] acc);
    return ((acc + RND) >>> SH_R) <<< SH_L;
  endfunction

  function automatic logic signed [OW-1:0] clamp(input logic signed [OW-1:0] v,
                                                 input logic signed [OW-1:0] lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  localparam logic signed [OW-1:0] PI_OUT  = to_out(OW'(PI_ACC));
  localparam logic signed [OW-1:0] HPI_OUT = to_out(OW'(HALF_PI_ACC));

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] prev_vld;
  logic [NS-1:0] rdy;

  always_comb begin
    logic [NS-1:0] low_mask;
    for (int k = 0; k < NS; k++) begin
      low_mask = ~({NS{1'b1}} << k);
      rdy[k]   = out_euler.ready || ((vld_r | low_mask) != {NS{1'b1}});
    end
    prev_vld = {vld_r[NS-2:0], in_quat.valid};
    vld_nxt  = (rdy & prev_vld) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_quat.ready = rdy[0];

  logic signed [COMP_W-1:0] cx;
  logic signed [COMP_W-1:0] cy;
  logic signed [COMP_W-1:0] cz;
  logic signed [COMP_W-1:0] cw;

  assign cx = COMP_W'(in_quat.quat_x >>> LSH);
  assign cy = COMP_W'(in_quat.quat_y >>> LSH);
  assign cz = COMP_W'(in_quat.quat_z >>> LSH);
  assign cw = COMP_W'(in_quat.quat_w >>> LSH);

  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, zw_r, yw_r, xz_r, xw_r, yz_r;
  logic                     zero0_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      xx_r    <= cx * cx;
      yy_r    <= cy * cy;
      zz_r    <= cz * cz;
      ww_r    <= cw * cw;
      xy_r    <= cx * cy;
      zw_r    <= cz * cw;
      yw_r    <= cy * cw;
      xz_r    <= cx * cz;
      xw_r    <= cx * cw;
      yz_r    <= cy * cz;
      zero0_r <= (in_quat.quat_x == '0) && (in_quat.quat_y == '0) &&
                 (in_quat.quat_z == '0) && (in_quat.quat_w == '0);
    end
  end

  args_t                   arg_r [ST_SUM:ST_PMUL];
  args_t                   arg1_nxt;
  logic signed [ARG_W-1:0] n1_r;
  logic signed [ARG_W-1:0] p1_r;

  always_comb begin
    arg1_nxt.zero   = zero0_r;
    arg1_nxt.yaw_y  = (ARG_W'(yw_r) - ARG_W'(xz_r)) <<< 1;
    arg1_nxt.yaw_x  = ARG_W'(xx_r) - ARG_W'(yy_r) - ARG_W'(zz_r) + ARG_W'(ww_r);
    arg1_nxt.roll_y = (ARG_W'(xw_r) - ARG_W'(yz_r)) <<< 1;
    arg1_nxt.roll_x = ARG_W'(yy_r) - ARG_W'(xx_r) - ARG_W'(zz_r) + ARG_W'(ww_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      arg_r[ST_SUM] <= arg1_nxt;
      n1_r <= ARG_W'(xx_r) + ARG_W'(yy_r) + ARG_W'(zz_r) + ARG_W'(ww_r);
      p1_r <= (ARG_W'(xy_r) + ARG_W'(zw_r)) <<< 1;
    end
  end

  logic [5:0]              nmsb;
  logic [KW-1:0]           k_nxt;
  logic signed [ARG_W-1:0] n2_r;
  logic signed [ARG_W-1:0] p2_r;
  logic [KW-1:0]           k2_r;

  always_comb begin
    nmsb = '0;
    for (int i = 0; i < ARG_W; i++) begin
      if (n1_r[i]) begin
        nmsb = 6'(i);
      end
    end
    k_nxt = (nmsb >= 6'(NS_W)) ? KW'(nmsb - 6'(NS_W - 1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PMSB]) begin
      arg_r[ST_PMSB] <= arg_r[ST_SUM];
      n2_r <= n1_r;
      p2_r <= p1_r;
      k2_r <= k_nxt;
    end
  end

  logic [NS_W-1:0]        n3_r;
  logic signed [PS_W-1:0] p3_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_PSH]) begin
      arg_r[ST_PSH] <= arg_r[ST_PMSB];
      n3_r <= NS_W'(n2_r >> k2_r);
      p3_r <= PS_W'(p2_r >>> k2_r);
    end
  end

  logic [PS_W-1:0]       ap;
  logic [2*NS_W-1:0]     nn;
  logic [2*RT_W-1:0]     pp;
  logic [2*NS_W-1:0]     nn4_r;
  logic [2*RT_W-1:0]     pp4_r;
  logic                  ge4_r;
  logic signed [PS_W-1:0] p4_r;

  always_comb begin
    ap = p3_r[PS_W-1] ? PS_W'(-p3_r) : PS_W'(p3_r);
    nn = n3_r * n3_r;
    pp = ap[RT_W-1:0] * ap[RT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PMUL]) begin
      arg_r[ST_PMUL] <= arg_r[ST_PSH];
      nn4_r <= nn;
      pp4_r <= pp;
      ge4_r <= (ap >= PS_W'(n3_r));
      p4_r  <= p3_r;
    end
  end

  sqrt_t sq_c [SQRT_STEPS+1];
  side_t sd_c [SQRT_STEPS+1];
  sqrt_t sq5_r;
  side_t sd5_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_PSUB]) begin
      sq5_r.v   <= ge4_r ? '0 : SQ_W'(nn4_r) - SQ_W'(pp4_r);
      sq5_r.res <= '0;
      sd5_r.a   <= arg_r[ST_PMUL];
      sd5_r.p   <= p4_r;
    end
  end

  assign sq_c[0] = sq5_r;
  assign sd_c[0] = sd5_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qte_sqrt_cell #(.STEP(g)) u_cell (
      .clk    (clk),
      .en     (rdy[ST_SQRT+g]),
      .d_i    (sq_c[g]),
      .side_i (sd_c[g]),
      .d_o    (sq_c[g+1]),
      .side_o (sd_c[g+1])
    );
  end

  side_t                   sd_end;
  logic signed [ARG_W-1:0] pitch_x;
  cordic_t [LANES-1:0]     cl [CORDIC_STEPS+1];
  logic                    zc [CORDIC_STEPS+1];
  logic                    zero_na_r;
  logic                    zero_nb_r;

  assign sd_end  = sd_c[SQRT_STEPS];
  assign pitch_x = $signed({{(ARG_W - RT_W){1'b0}}, sq_c[SQRT_STEPS].res[RT_W-1:0]});

  qte_norm u_norm_yaw (
    .clk  (clk),
    .en_a (rdy[ST_NA]),
    .en_b (rdy[ST_NB]),
    .y_i  (sd_end.a.yaw_y),
    .x_i  (sd_end.a.yaw_x),
    .c_o  (cl[0][LANE_YAW])
  );

  qte_norm u_norm_pitch (
    .clk  (clk),
    .en_a (rdy[ST_NA]),
    .en_b (rdy[ST_NB]),
    .y_i  (ARG_W'(sd_end.p)),
    .x_i  (pitch_x),
    .c_o  (cl[0][LANE_PITCH])
  );

  qte_norm u_norm_roll (
    .clk  (clk),
    .en_a (rdy[ST_NA]),
    .en_b (rdy[ST_NB]),
    .y_i  (sd_end.a.roll_y),
    .x_i  (sd_end.a.roll_x),
    .c_o  (cl[0][LANE_ROLL])
  );

  always_ff @(posedge clk) begin
    if (rdy[ST_NA]) begin
      zero_na_r <= sd_end.a.zero;
    end
    if (rdy[ST_NB]) begin
      zero_nb_r <= zero_na_r;
    end
  end

  assign zc[0] = zero_nb_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    qte_cordic_cell #(.STEP(g)) u_cell (
      .clk    (clk),
      .en     (rdy[ST_CORD+g]),
      .lane_i (cl[g]),
      .zero_i (zc[g]),
      .lane_o (cl[g+1]),
      .zero_o (zc[g+1])
    );
  end

  logic signed [ANGLE_BITS-1:0] yaw_nxt, roll_nxt, yaw_r, roll_r;
  logic signed [ANGLE_BITS-2:0] pitch_nxt, pitch_r;
  logic                         zero_r;

  always_comb begin
    logic signed [OW-1:0] acc [LANES];
    for (int l = 0; l < LANES; l++) begin
      acc[l] = cl[CORDIC_STEPS][l].nul ? '0 : OW'(cl[CORDIC_STEPS][l].z);
    end
    yaw_nxt   = ANGLE_BITS'(clamp(to_out(acc[LANE_YAW]), PI_OUT));
    pitch_nxt = (ANGLE_BITS - 1)'(clamp(to_out(acc[LANE_PITCH]), HPI_OUT));
    roll_nxt  = ANGLE_BITS'(clamp(to_out(acc[LANE_ROLL]), PI_OUT));
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      zero_r  <= zc[CORDIC_STEPS];
    end
  end

  assign out_euler.valid       = vld_r[ST_OUT];
  assign out_euler.yaw_angle   = yaw_r;
  assign out_euler.pitch_angle = pitch_r;
  assign out_euler.roll_angle  = roll_r;
  assign out_euler.zero_norm   = zero_r;

  // A zero-length quaternion must come out with all three angles at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_euler.valid && out_euler.zero_norm) |->
      (out_euler.yaw_angle == '0 && out_euler.pitch_angle == '0 &&
       out_euler.roll_angle == '0))
    else $error("zero quaternion gave a nonzero angle");

  // Any empty stage in the chain must leave room for a new request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r != {NS{1'b1}}) |-> in_quat.ready)
    else $error("input stalled while the chain has a bubble");

  // An accepted request must occupy the first stage on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_quat.valid && in_quat.ready) |=> vld_r[ST_PROD])
    else $error("accepted request was lost at the first stage");

endmodule
